/* design/hfla_pkg.sv */
// ============================================================================
// hfla_pkg
// shared widths, condition codes and types of the hex float long adder
// ============================================================================
package hfla_pkg;

   localparam int FracW   = 56;
   localparam int ExpW    = 7;
   localparam int DigitW  = 4;
   localparam int Digits  = FracW / DigitW;
   localparam int CntW    = 4;
   localparam int MaxDiff = 14;

   typedef logic [1:0] cc_type;

   localparam cc_type CC_ZERO = 2'd0;
   localparam cc_type CC_NEG  = 2'd1;
   localparam cc_type CC_POS  = 2'd2;
   localparam cc_type CC_OVF  = 2'd3;

   typedef struct packed {
      logic            zero;
      logic [CntW-1:0] count;
   } lzc_type;

endpackage

/* design/hfla_lzc.sv */
// ============================================================================
// hfla_lzc
// leading zero hex digit count of a long fraction, with zero detect
// ============================================================================
module hfla_lzc (
   input  logic [hfla_pkg::FracW-1:0] frac,
   output hfla_pkg::lzc_type          lzc
);

   always_comb begin
      lzc.zero  = 1'b1;
      lzc.count = '0;
      // highest nonzero digit wins
      for (int i = 0; i < hfla_pkg::Digits; i++) begin
         if (frac[i*hfla_pkg::DigitW +: hfla_pkg::DigitW] != '0) begin
            lzc.zero  = 1'b0;
            lzc.count = hfla_pkg::CntW'(hfla_pkg::Digits - 1 - i);
         end
      end
   end

endmodule

/* design/hex_float_long_adder_unit.sv */
// ============================================================================
// hex_float_long_adder_unit
// five stage pipelined adder for 64-bit hexadecimal floating-point words
// ============================================================================
// One add enters per cycle unless the input side is stalled, and passes
// exponent compare and operand swap, hex-digit alignment shift, fraction add
// or subtract with carry digit, leading digit count, then normalize (if
// req_mode is set) and pack into the output register. A stall on the result
// side freezes every stage together, so the input side is stalled only while
// a finished result waits and cannot move; nothing is dropped or repeated.
module hex_float_long_adder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [63:0]           req_operand_a,
   input  logic [63:0]           req_operand_b,
   input  logic                  req_mode,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_result_word,
   output hfla_pkg::cc_type      rsp_cond_code
);

   localparam int FW = hfla_pkg::FracW;
   localparam int EW = hfla_pkg::ExpW;

   logic advance;

   // stage 1: compare and swap
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_mode_ff, s1_sign_ff, s1_unlike_ff, s1_shift_b_ff;
   logic [EW-1:0] s1_exp_ff;
   logic [3:0]    s1_amt_ff;
   logic [FW-1:0] s1_fa_ff, s1_fb_ff;
   logic          s1_sign_in, s1_unlike_in, s1_shift_b_in;
   logic [EW-1:0] s1_exp_in;
   logic [3:0]    s1_amt_in;
   logic [FW-1:0] s1_fa_in, s1_fb_in;

   // stage 2: aligned
   logic          s2_valid_ff, s2_mode_ff, s2_sign_ff, s2_unlike_ff;
   logic [EW-1:0] s2_exp_ff;
   logic [FW-1:0] s2_fa_ff, s2_fb_ff;
   logic [FW-1:0] s2_fa_in, s2_fb_in, s2_shifted;

   // stage 3: summed
   logic          s3_valid_ff, s3_mode_ff, s3_sign_ff;
   logic [EW:0]   s3_exp_ff, s3_exp_in;
   logic [FW-1:0] s3_frac_ff, s3_frac_in;
   logic          s3_sign_in;
   logic [FW:0]   sum_ab, dif_ab, dif_ba, raw;

   // stage 4: counted
   logic              s4_valid_ff, s4_mode_ff, s4_sign_ff;
   logic [EW:0]       s4_exp_ff;
   logic [FW-1:0]     s4_frac_ff;
   hfla_pkg::lzc_type s4_lzc_ff, s4_lzc_in;

   // output register
   logic             rsp_valid_ff;
   logic [63:0]      rsp_word_ff, rsp_word_in;
   hfla_pkg::cc_type rsp_cc_ff, rsp_cc_in;
   logic [EW+1:0]    norm_exp;
   logic [FW-1:0]    norm_frac;

   logic [EW-1:0] ea, eb, diff;
   logic          sa, sb, a_gt;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign s1_valid_in = req_valid;

   always_comb begin
      sa   = req_operand_a[63];
      sb   = req_operand_b[63];
      ea   = req_operand_a[62:56];
      eb   = req_operand_b[62:56];
      a_gt = ea > eb;
      diff = a_gt ? (ea - eb) : (eb - ea);
      s1_exp_in = a_gt ? ea : eb;
      if (diff > EW'(hfla_pkg::MaxDiff)) begin
         // far apart: larger operand passes through
         s1_sign_in    = a_gt ? sa : sb;
         s1_fa_in      = a_gt ? req_operand_a[FW-1:0] : req_operand_b[FW-1:0];
         s1_fb_in      = '0;
         s1_unlike_in  = 1'b0;
         s1_shift_b_in = 1'b0;
         s1_amt_in     = '0;
      end else begin
         s1_sign_in    = sa;
         s1_fa_in      = req_operand_a[FW-1:0];
         s1_fb_in      = req_operand_b[FW-1:0];
         s1_unlike_in  = sa ^ sb;
         s1_shift_b_in = a_gt;
         s1_amt_in     = diff[3:0];
      end
   end

   always_comb begin
      s2_shifted = (s1_shift_b_ff ? s1_fb_ff : s1_fa_ff) >> {s1_amt_ff, 2'b00};
      s2_fa_in   = s1_shift_b_ff ? s1_fa_ff : s2_shifted;
      s2_fb_in   = s1_shift_b_ff ? s2_shifted : s1_fb_ff;
   end

   always_comb begin
      sum_ab = {1'b0, s2_fa_ff} + {1'b0, s2_fb_ff};
      dif_ab = {1'b0, s2_fa_ff} - {1'b0, s2_fb_ff};
      dif_ba = {1'b0, s2_fb_ff} - {1'b0, s2_fa_ff};
      s3_sign_in = s2_sign_ff;
      if (!s2_unlike_ff) begin
         raw = sum_ab;
      end else if (!dif_ab[FW]) begin
         raw = dif_ab;
      end else begin
         raw = dif_ba;
         s3_sign_in = !s2_sign_ff;
      end
      // carry digit
      if (raw[FW]) begin
         s3_frac_in = {3'b000, raw[FW:4]};
         s3_exp_in  = {1'b0, s2_exp_ff} + (EW+1)'(1);
      end else begin
         s3_frac_in = raw[FW-1:0];
         s3_exp_in  = {1'b0, s2_exp_ff};
      end
   end

   hfla_lzc u_lzc (
      .frac (s3_frac_ff),
      .lzc  (s4_lzc_in)
   );

   always_comb begin
      if (s4_mode_ff) begin
         norm_exp  = {1'b0, s4_exp_ff} - (EW+2)'(s4_lzc_ff.count);
         norm_frac = s4_frac_ff << {s4_lzc_ff.count, 2'b00};
      end else begin
         norm_exp  = {1'b0, s4_exp_ff};
         norm_frac = s4_frac_ff;
      end
      if (s4_lzc_ff.zero) begin
         rsp_word_in = '0;
         rsp_cc_in   = hfla_pkg::CC_ZERO;
      end else if (norm_exp[EW+1]) begin
         // underflow
         rsp_word_in = '0;
         rsp_cc_in   = hfla_pkg::CC_OVF;
      end else begin
         rsp_word_in = {s4_sign_ff, norm_exp[EW-1:0], norm_frac};
         if (norm_exp[EW]) begin
            rsp_cc_in = hfla_pkg::CC_OVF;
         end else if (s4_sign_ff) begin
            rsp_cc_in = hfla_pkg::CC_NEG;
         end else begin
            rsp_cc_in = hfla_pkg::CC_POS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff    <= req_mode;
         s1_sign_ff    <= s1_sign_in;
         s1_unlike_ff  <= s1_unlike_in;
         s1_shift_b_ff <= s1_shift_b_in;
         s1_exp_ff     <= s1_exp_in;
         s1_amt_ff     <= s1_amt_in;
         s1_fa_ff      <= s1_fa_in;
         s1_fb_ff      <= s1_fb_in;

         s2_mode_ff    <= s1_mode_ff;
         s2_sign_ff    <= s1_sign_ff;
         s2_unlike_ff  <= s1_unlike_ff;
         s2_exp_ff     <= s1_exp_ff;
         s2_fa_ff      <= s2_fa_in;
         s2_fb_ff      <= s2_fb_in;

         s3_mode_ff    <= s2_mode_ff;
         s3_sign_ff    <= s3_sign_in;
         s3_exp_ff     <= s3_exp_in;
         s3_frac_ff    <= s3_frac_in;

         s4_mode_ff    <= s3_mode_ff;
         s4_sign_ff    <= s3_sign_ff;
         s4_exp_ff     <= s3_exp_ff;
         s4_frac_ff    <= s3_frac_ff;
         s4_lzc_ff     <= s4_lzc_in;

         rsp_word_ff   <= rsp_word_in;
         rsp_cc_ff     <= rsp_cc_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;
   assign rsp_cond_code   = rsp_cc_ff;

endmodule
